@@ rtl/swv_pkg.sv @@
// Shared types and constants for the per-track sliding window vote block.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package swv_pkg;

    // Field and register widths fixed by the interface
    localparam int TRACK_W   = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'd1;

    // Register reset values
    localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 6'd8;
    localparam logic [CFG_W-1:0] THRESHOLD_RST  = 6'd4;

    // Operation codes
    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_DROP    = 1'b1;

    // Width used when comparing counts against the threshold register
    localparam int CMP_W = 7;

    // Control from the sequencer to the slot table
    typedef struct packed {
        logic rd_en;      // read entry and valid bit at the read address
        logic wr_en;      // write entry at the write address
        logic set_valid;  // mark the write address valid
        logic clr_valid;  // mark the write address free
        logic clr_all;    // free every slot
    } tbl_ctl_t;

endpackage

@@ rtl/swv_if.sv @@
// Handshake interfaces for the request and response words.
// Depends on swv_pkg for field widths.
`timescale 1ns / 1ps

interface swv_req_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic                        has_track;
    logic [swv_pkg::TRACK_W-1:0] track_key;
    logic                        event_seen;

    modport source (output valid, op, has_track, track_key, event_seen, input ready);
    modport sink   (input valid, op, has_track, track_key, event_seen, output ready);
endinterface

interface swv_rsp_if;
    logic valid;
    logic ready;
    logic decision;
    logic table_overflow;

    modport source (output valid, decision, table_overflow, input ready);
    modport sink   (input valid, decision, table_overflow, output ready);
endinterface

@@ rtl/per_track_sliding_window_vote.sv @@
// Per-track sliding window majority vote, top level: sequencer, registers
// and output stage. Depends on swv_pkg, swv_if, swv_table and swv_window.
`timescale 1ns / 1ps

// One word is handled at a time. The slot table is searched by a single
// compare unit, one slot per cycle through the table's registered read port.
// An observe word passes through accept, scan, update and output steps, the
// scan ending early once the track is found; an observe word without a track
// goes from accept straight to output. The output step also waits while an
// earlier result still sits unread in the output register. A drop word goes
// through accept, scan and update only and gives no result. The search stops
// at the first slot holding the track, and a new track takes the lowest free
// slot. Writing window_len frees every slot at once, so no clearing pass is
// needed after reset or a length change.
module per_track_sliding_window_vote #(
    parameter int TRACK_SLOTS = 64,
    parameter int WINDOW_MAX  = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    swv_req_if.sink                       req,
    swv_rsp_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [swv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [swv_pkg::CFG_W-1:0]     cfg_data
);

    localparam int AW     = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int SCW    = $clog2(TRACK_SLOTS + 1);
    localparam int CW     = $clog2(WINDOW_MAX + 1);
    localparam int WIN_IW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int TW     = swv_pkg::TRACK_W;
    localparam int DW     = TW + WINDOW_MAX + 2 * CW;

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_CALC   = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [swv_pkg::CFG_W-1:0]   window_len_reg, window_len_next;
    logic [swv_pkg::CFG_W-1:0]   threshold_reg, threshold_next;
    logic                        op_reg, op_next;
    logic                        ev_reg, ev_next;
    logic [TW-1:0]               id_reg, id_next;
    logic [SCW-1:0]              cnt_reg, cnt_next;
    logic                        rd_live_reg, rd_live_next;
    logic [AW-1:0]               rd_idx_reg, rd_idx_next;
    logic                        hit_reg, hit_next;
    logic [AW-1:0]               slot_reg, slot_next;
    logic                        free_found_reg, free_found_next;
    logic [AW-1:0]               free_reg, free_next;
    logic [WINDOW_MAX-1:0]       bits_reg, bits_next;
    logic [CW-1:0]               fill_reg, fill_next;
    logic [CW-1:0]               ones_reg, ones_next;
    logic                        res_dec_reg, res_dec_next;
    logic                        res_ovf_reg, res_ovf_next;
    logic                        out_valid_reg, out_valid_next;
    logic                        out_dec_reg, out_dec_next;
    logic                        out_ovf_reg, out_ovf_next;

    swv_pkg::tbl_ctl_t           ctl;
    logic [AW-1:0]               wr_addr;
    logic [DW-1:0]               wr_data;
    logic [DW-1:0]               rd_data;
    logic                        rd_valid;
    logic [TW-1:0]               rd_track;
    logic                        scan_match;
    logic                        scan_last;
    logic                        accept;
    logic [CW-1:0]               n_eff;
    logic [WINDOW_MAX-1:0]       win_bits;
    logic [CW-1:0]               win_fill;
    logic [CW-1:0]               win_ones;
    logic                        win_dec;

    // Effective window length, clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (window_len_reg == '0)
        begin
            n_eff = CW'(1);
        end
        else if (swv_pkg::CMP_W'(window_len_reg) > swv_pkg::CMP_W'(WINDOW_MAX))
        begin
            n_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = CW'(window_len_reg);
        end
    end

    // Configuration registers
    always_comb
    begin
        window_len_next = window_len_reg;
        threshold_next  = threshold_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                swv_pkg::CFG_WINDOW_LEN: window_len_next = cfg_data;
                swv_pkg::CFG_THRESHOLD:  threshold_next  = cfg_data;
                default:                 ;
            endcase
        end
    end

    // Unpack the entry being read
    assign rd_track   = rd_data[DW-1 -: TW];
    assign scan_match = rd_live_reg && rd_valid && (rd_track == id_reg);
    assign scan_last  = (cnt_reg == SCW'(TRACK_SLOTS));
    assign accept     = req.valid && req.ready;

    // Window update unit
    swv_window #(
        .WIN    (WINDOW_MAX),
        .CW     (CW),
        .WIN_IW (WIN_IW)
    ) u_window (
        .hit      (hit_reg),
        .ev       (ev_reg),
        .n        (n_eff),
        .thr      (threshold_reg),
        .bits_in  (bits_reg),
        .fill_in  (fill_reg),
        .ones_in  (ones_reg),
        .bits_out (win_bits),
        .fill_out (win_fill),
        .ones_out (win_ones),
        .decision (win_dec)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        ev_next         = ev_reg;
        id_next         = id_reg;
        cnt_next        = cnt_reg;
        rd_live_next    = 1'b0;
        rd_idx_next     = cnt_reg[AW-1:0];
        hit_next        = hit_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        free_next       = free_reg;
        bits_next       = bits_reg;
        fill_next       = fill_reg;
        ones_next       = ones_reg;
        res_dec_next    = res_dec_reg;
        res_ovf_next    = res_ovf_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_dec_next    = out_dec_reg;
        out_ovf_next    = out_ovf_reg;
        ctl             = '0;
        ctl.clr_all     = cfg_we && (cfg_index == swv_pkg::CFG_WINDOW_LEN);
        wr_addr         = hit_reg ? slot_reg : free_reg;
        wr_data         = {id_reg, win_bits, win_fill, win_ones};

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = req.op;
                    ev_next         = req.event_seen;
                    id_next         = req.track_key;
                    cnt_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    res_dec_next    = 1'b0;
                    res_ovf_next    = 1'b0;
                    if (req.op == swv_pkg::OP_OBSERVE && !req.has_track)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // issue the next read while checking the previous one
                if (!scan_last)
                begin
                    ctl.rd_en    = 1'b1;
                    rd_live_next = 1'b1;
                    cnt_next     = cnt_reg + SCW'(1);
                end
                if (rd_live_reg && !rd_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_next       = rd_idx_reg;
                end
                if (scan_match)
                begin
                    hit_next     = 1'b1;
                    slot_next    = rd_idx_reg;
                    bits_next    = rd_data[2*CW +: WINDOW_MAX];
                    fill_next    = rd_data[CW +: CW];
                    ones_next    = rd_data[0 +: CW];
                    rd_live_next = 1'b0;
                    state_next   = ST_CALC;
                end
                else if (scan_last)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (op_reg == swv_pkg::OP_DROP)
                begin
                    wr_addr       = slot_reg;
                    ctl.clr_valid = hit_reg;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    ctl.wr_en     = hit_reg || free_found_reg;
                    ctl.set_valid = !hit_reg && free_found_reg;
                    res_dec_next  = (hit_reg || free_found_reg) && win_dec;
                    res_ovf_next  = !hit_reg && !free_found_reg;
                    state_next    = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hand over once the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dec_next   = res_dec_reg;
                    out_ovf_next   = res_ovf_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Slot table
    swv_table #(
        .SLOTS (TRACK_SLOTS),
        .AW    (AW),
        .DW    (DW)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .rd_addr  (cnt_reg[AW-1:0]),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            window_len_reg <= swv_pkg::WINDOW_LEN_RST;
            threshold_reg  <= swv_pkg::THRESHOLD_RST;
            cnt_reg        <= '0;
            rd_live_reg    <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            window_len_reg <= window_len_next;
            threshold_reg  <= threshold_next;
            cnt_reg        <= cnt_next;
            rd_live_reg    <= rd_live_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        ev_reg      <= ev_next;
        id_reg      <= id_next;
        rd_idx_reg  <= rd_idx_next;
        slot_reg    <= slot_next;
        free_reg    <= free_next;
        bits_reg    <= bits_next;
        fill_reg    <= fill_next;
        ones_reg    <= ones_next;
        res_dec_reg <= res_dec_next;
        res_ovf_reg <= res_ovf_next;
        out_dec_reg <= out_dec_next;
        out_ovf_reg <= out_ovf_next;
    end

    assign req.ready          = (state_reg == ST_IDLE);
    assign rsp.valid          = out_valid_reg;
    assign rsp.decision       = out_dec_reg;
    assign rsp.table_overflow = out_ovf_reg;

    // Checks
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != ST_IDLE)
        else $error("sequencer idle straight after accepting a word");

    a_write_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.wr_en |-> (state_reg == ST_CALC) && (op_reg == swv_pkg::OP_OBSERVE))
        else $error("table written outside the update of an observe word");

    a_vote_or_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_dec_reg && out_ovf_reg))
        else $error("vote raised together with table overflow");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= SCW'(TRACK_SLOTS))
        else $error("scan counter ran past the table");

    a_calc_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CALC |-> $past(state_reg) == ST_SCAN)
        else $error("update entered without a table scan");

endmodule

@@ rtl/swv_table.sv @@
// Slot table: entry memory with one write and one registered read port,
// plus per-slot valid flags held in flops. Depends on swv_pkg.
`timescale 1ns / 1ps

module swv_table #(
    parameter int SLOTS = 64,
    parameter int AW    = 6,
    parameter int DW    = 76
) (
    input  logic              clk,
    input  logic              rst_n,
    input  swv_pkg::tbl_ctl_t ctl,
    input  logic [AW-1:0]     rd_addr,
    input  logic [AW-1:0]     wr_addr,
    input  logic [DW-1:0]     wr_data,
    output logic [DW-1:0]     rd_data,
    output logic              rd_valid
);

    logic [DW-1:0]    mem [SLOTS];
    logic [DW-1:0]    rd_data_reg;
    logic             rd_valid_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    // Entry storage, no reset
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of entry and its flag
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    // Valid flags: a table clear wins over single-slot updates
    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.clr_all)
        begin
            valid_next = '0;
        end
        else if (ctl.set_valid)
        begin
            valid_next[wr_addr] = 1'b1;
        end
        else if (ctl.clr_valid)
        begin
            valid_next[wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign rd_data  = rd_data_reg;
    assign rd_valid = rd_valid_reg;

endmodule

@@ rtl/swv_window.sv @@
// Window update datapath: shifts one vote into a slot's window and keeps the
// fill and ones counts in step, then forms the vote. Depends on swv_pkg.
`timescale 1ns / 1ps

module swv_window #(
    parameter int WIN    = 32,
    parameter int CW     = 6,
    parameter int WIN_IW = 5
) (
    input  logic                      hit,
    input  logic                      ev,
    input  logic [CW-1:0]             n,
    input  logic [swv_pkg::CFG_W-1:0] thr,
    input  logic [WIN-1:0]            bits_in,
    input  logic [CW-1:0]             fill_in,
    input  logic [CW-1:0]             ones_in,
    output logic [WIN-1:0]            bits_out,
    output logic [CW-1:0]             fill_out,
    output logic [CW-1:0]             ones_out,
    output logic                      decision
);

    logic [WIN-1:0]    len_mask;
    logic [CW-1:0]     fill_cl;
    logic              full;
    logic              oldest;
    logic [CW-1:0]     n_m1;
    logic [WIN-1:0]    shifted;

    // Mask of the lowest n window positions
    always_comb
    begin
        for (int i = 0; i < WIN; i++)
        begin
            len_mask[i] = (CW'(i) < n);
        end
    end

    assign fill_cl = (fill_in > n) ? n : fill_in;
    assign full    = (fill_cl == n);
    assign n_m1    = n - CW'(1);
    assign oldest  = bits_in[n_m1[WIN_IW-1:0]];
    assign shifted = ((bits_in << 1) | WIN'(ev)) & len_mask;

    // Existing slot shifts, new slot starts with a single vote
    always_comb
    begin
        if (hit)
        begin
            bits_out = shifted;
            ones_out = ones_in + CW'(ev) - CW'(full & oldest);
            fill_out = full ? n : (fill_cl + CW'(1));
        end
        else
        begin
            bits_out = WIN'(ev);
            ones_out = CW'(ev);
            fill_out = CW'(1);
        end
    end

    // Vote once the window is full and ones exceed the threshold
    assign decision = (fill_out >= n) &&
                      (swv_pkg::CMP_W'(ones_out) > swv_pkg::CMP_W'(thr));

endmodule
